[rtl/core/s1md_pkg.sv]
`default_nettype none

package s1md_pkg;

  // chaining values loaded at reset and after every digest
  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // round constants, one per group of twenty rounds
  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  localparam logic [6:0] ROUND_G1   = 7'd20;
  localparam logic [6:0] ROUND_G2   = 7'd40;
  localparam logic [6:0] ROUND_G3   = 7'd60;
  localparam logic [6:0] LOAD_LAST  = 7'd15;
  localparam logic [6:0] ROUND_LAST = 7'd79;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  // word slot of the block where the 64-bit length starts
  localparam logic [3:0] LEN_HI_IDX = 4'd14;

  localparam logic [2:0] LAST_IDX   = 3'd4;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // one big-endian message word on its way to the compression engine
  typedef struct packed {
    logic        msg_end;  // final word of the final block of a message
    logic [31:0] data;
  } blk_word_t;

endpackage

`default_nettype wire

[rtl/core/s1md_front.sv]
`default_nettype none

module s1md_front
  import s1md_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_tvalid_i,
  output logic            s_tready_o,
  input  wire logic [7:0] s_tdata_i,
  input  wire logic       s_tuser_i,
  input  wire logic       s_tlast_i,
  output logic            push_o,
  output blk_word_t       push_word_o,
  input  wire logic       full_i
);

  typedef enum logic [4:0] {
    F_RUN   = 5'b00001,
    F_PAD   = 5'b00010,
    F_ZERO  = 5'b00100,
    F_LENHI = 5'b01000,
    F_LENLO = 5'b10000
  } front_state_e;

  front_state_e state_q, state_d;
  logic [1:0]   byte_cnt_q, byte_cnt_d;
  logic [23:0]  acc_q, acc_d;
  logic [3:0]   word_cnt_q, word_cnt_d;
  logic [63:0]  bits_q, bits_d;
  logic [31:0]  pad_word;

  assign s_tready_o = (state_q == F_RUN) && !full_i;

  // partial word closed by the 0x80 marker
  always_comb begin
    unique case (byte_cnt_q)
      2'd0:    pad_word = {PAD_BYTE, 24'h0};
      2'd1:    pad_word = {acc_q[7:0], PAD_BYTE, 16'h0};
      2'd2:    pad_word = {acc_q[15:0], PAD_BYTE, 8'h0};
      default: pad_word = {acc_q[23:0], PAD_BYTE};
    endcase
  end

  always_comb begin
    state_d     = state_q;
    byte_cnt_d  = byte_cnt_q;
    acc_d       = acc_q;
    word_cnt_d  = word_cnt_q;
    bits_d      = bits_q;
    push_o      = 1'b0;
    push_word_o = '0;
    unique case (state_q)
      F_RUN: begin
        if (s_tvalid_i && s_tready_o) begin
          if (s_tuser_i) begin
            acc_d      = {acc_q[15:0], s_tdata_i};
            byte_cnt_d = byte_cnt_q + 2'd1;
            bits_d     = bits_q + 64'd8;
            if (byte_cnt_q == 2'd3) begin
              push_o           = 1'b1;
              push_word_o.data = {acc_q, s_tdata_i};
              word_cnt_d       = word_cnt_q + 4'd1;
            end
          end
          if (s_tlast_i) begin
            state_d = F_PAD;
          end
        end
      end
      F_PAD: begin
        if (!full_i) begin
          push_o           = 1'b1;
          push_word_o.data = pad_word;
          word_cnt_d       = word_cnt_q + 4'd1;
          byte_cnt_d       = 2'd0;
          state_d          = F_ZERO;
        end
      end
      F_ZERO: begin
        // zero-fill, wrapping into a new block if the marker landed late
        if (word_cnt_q == LEN_HI_IDX) begin
          state_d = F_LENHI;
        end else if (!full_i) begin
          push_o     = 1'b1;
          word_cnt_d = word_cnt_q + 4'd1;
        end
      end
      F_LENHI: begin
        if (!full_i) begin
          push_o           = 1'b1;
          push_word_o.data = bits_q[63:32];
          word_cnt_d       = word_cnt_q + 4'd1;
          state_d          = F_LENLO;
        end
      end
      F_LENLO: begin
        if (!full_i) begin
          push_o              = 1'b1;
          push_word_o.data    = bits_q[31:0];
          push_word_o.msg_end = 1'b1;
          word_cnt_d          = 4'd0;
          bits_d              = 64'd0;
          state_d             = F_RUN;
        end
      end
      default: state_d = F_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_RUN;
      byte_cnt_q <= 2'd0;
      word_cnt_q <= 4'd0;
      bits_q     <= 64'd0;
    end else begin
      state_q    <= state_d;
      byte_cnt_q <= byte_cnt_d;
      word_cnt_q <= word_cnt_d;
      bits_q     <= bits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

endmodule

`default_nettype wire

[rtl/core/s1md_fifo.sv]
`default_nettype none

module s1md_fifo
  import s1md_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  var  blk_word_t push_word_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output blk_word_t      pop_word_o
);

  blk_word_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]     count_q, count_d;

  assign full_o     = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_word_o = mem[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (FIFO_AW+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/s1md_back.sv]
`default_nettype none

module s1md_back
  import s1md_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        word_valid_i,
  input  var  blk_word_t   word_i,
  output logic             pop_o,
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [31:0]      m_tdata_o,
  output logic [2:0]       m_tuser_o,
  output logic             m_tlast_o
);

  typedef enum logic [3:0] {
    B_LOAD  = 4'b0001,
    B_ROUND = 4'b0010,
    B_ADD   = 4'b0100,
    B_EMIT  = 4'b1000
  } back_state_e;

  back_state_e state_q, state_d;
  logic [6:0]  round_q, round_d;
  logic        last_q, last_d;
  logic [2:0]  idx_q, idx_d;
  logic        m_tvalid_q, m_tvalid_d;
  logic [31:0] m_tdata_q;
  logic [2:0]  m_tuser_q;
  logic        m_tlast_q;

  logic [31:0] h_q [5];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] w_q [16];

  logic [31:0] w_mix, w_new, w_t, f, k, tmp;
  logic        do_round, out_free, load_out, emit_done;

  assign out_free  = !m_tvalid_q || m_tready_i;
  assign load_out  = (state_q == B_EMIT) && out_free;
  assign emit_done = load_out && (idx_q == LAST_IDX);
  assign pop_o     = (state_q == B_LOAD) && word_valid_i;
  assign do_round  = pop_o || (state_q == B_ROUND);

  // message schedule: w_q[0] is w[t-16], w_q[15] is w[t-1]
  assign w_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign w_t   = (state_q == B_LOAD) ? word_i.data : w_new;

  always_comb begin
    priority if (round_q < ROUND_G1) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = K_R0;
    end else if (round_q < ROUND_G2) begin
      f = b_q ^ c_q ^ d_q;
      k = K_R1;
    end else if (round_q < ROUND_G3) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = K_R2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = K_R3;
    end
  end

  assign tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_t;

  always_comb begin
    state_d    = state_q;
    round_d    = round_q;
    last_d     = last_q;
    idx_d      = idx_q;
    m_tvalid_d = m_tvalid_q;
    if (m_tready_i) begin
      m_tvalid_d = 1'b0;
    end
    unique case (state_q)
      B_LOAD: begin
        if (word_valid_i) begin
          round_d = round_q + 7'd1;
          if (round_q == LOAD_LAST) begin
            last_d  = word_i.msg_end;
            state_d = B_ROUND;
          end
        end
      end
      B_ROUND: begin
        round_d = round_q + 7'd1;
        if (round_q == ROUND_LAST) begin
          state_d = B_ADD;
        end
      end
      B_ADD: begin
        round_d = 7'd0;
        idx_d   = 3'd0;
        state_d = last_q ? B_EMIT : B_LOAD;
      end
      B_EMIT: begin
        if (out_free) begin
          m_tvalid_d = 1'b1;
          idx_d      = idx_q + 3'd1;
          if (idx_q == LAST_IDX) begin
            last_d  = 1'b0;
            state_d = B_LOAD;
          end
        end
      end
      default: state_d = B_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_LOAD;
      round_q    <= 7'd0;
      last_q     <= 1'b0;
      idx_q      <= 3'd0;
      m_tvalid_q <= 1'b0;
      h_q        <= H_INIT;
      a_q        <= H_INIT[0];
      b_q        <= H_INIT[1];
      c_q        <= H_INIT[2];
      d_q        <= H_INIT[3];
      e_q        <= H_INIT[4];
    end else begin
      state_q    <= state_d;
      round_q    <= round_d;
      last_q     <= last_d;
      idx_q      <= idx_d;
      m_tvalid_q <= m_tvalid_d;
      if (do_round) begin
        e_q <= d_q;
        d_q <= c_q;
        c_q <= {b_q[1:0], b_q[31:2]};
        b_q <= a_q;
        a_q <= tmp;
      end else if (state_q == B_ADD) begin
        // fold the block into the chain and seed the next block
        h_q[0] <= h_q[0] + a_q;
        h_q[1] <= h_q[1] + b_q;
        h_q[2] <= h_q[2] + c_q;
        h_q[3] <= h_q[3] + d_q;
        h_q[4] <= h_q[4] + e_q;
        a_q    <= h_q[0] + a_q;
        b_q    <= h_q[1] + b_q;
        c_q    <= h_q[2] + c_q;
        d_q    <= h_q[3] + d_q;
        e_q    <= h_q[4] + e_q;
      end else if (emit_done) begin
        h_q <= H_INIT;
        a_q <= H_INIT[0];
        b_q <= H_INIT[1];
        c_q <= H_INIT[2];
        d_q <= H_INIT[3];
        e_q <= H_INIT[4];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_round) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= w_t;
    end
    if (load_out) begin
      m_tdata_q <= h_q[idx_q];
      m_tuser_q <= idx_q;
      m_tlast_q <= (idx_q == LAST_IDX);
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;
  assign m_tuser_o  = m_tuser_q;
  assign m_tlast_o  = m_tlast_q;

endmodule

`default_nettype wire

[rtl/core/sha1_message_digest.sv]
// SHA-1 over a byte stream. Each input transfer carries one byte (tdata), a
// byte-valid flag (tuser) and an end-of-message mark (tlast); an end with
// tuser low closes the message without adding a byte, so an empty message is
// allowed. Bytes are taken one per cycle, while the queue has room, into a
// 4-word queue; the compression engine behind it handles each 64-byte block
// as 16 rounds while loading words, 64 more rounds and one chaining add. It
// takes no words during the 64 further rounds and the chaining add, so the
// queue fills after 16 bytes and the input stalls; the remaining 48 bytes
// are taken as the engine loads words. Long-message throughput is set by the
// queue depth and by the engine, which does one round per cycle (while
// loading, only when a word is waiting). On message end the input stalls
// while up to 18 padding and length words are queued; the last one or two
// blocks then finish, and the five digest words h0..h4 leave as five output
// transfers (tuser = word index, tlast on h4). The block then starts the
// next message from the initial chaining values.
`default_nettype none

module sha1_message_digest
  import s1md_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tuser_i,   // [0] byte_valid
  input  wire logic        s_axis_tlast_i,   // end_of_message
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]       m_axis_tuser_o,   // [2:0] word_index
  output logic             m_axis_tlast_o    // last_word
);

  logic      push, full, pop, word_valid;
  blk_word_t push_word, pop_word;

  s1md_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .s_tlast_i   (s_axis_tlast_i),
    .push_o      (push),
    .push_word_o (push_word),
    .full_i      (full)
  );

  s1md_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (word_valid),
    .pop_word_o  (pop_word)
  );

  s1md_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (word_valid),
    .word_i       (pop_word),
    .pop_o        (pop),
    .m_tvalid_o   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_o    (m_axis_tdata_o),
    .m_tuser_o    (m_axis_tuser_o),
    .m_tlast_o    (m_axis_tlast_o)
  );

endmodule

`default_nettype wire
